@@ hw/rtl/lla_pkg.sv @@
// Shared types, constants and codes for the life-like automaton grid block.
// Used by lla_ctrl, lla_dp and the top level; depends on nothing.
package lla_pkg;

  localparam int GRID_HEIGHT = 64;
  localparam int GRID_WIDTH  = 64;

  localparam int ROW_W  = $clog2(GRID_HEIGHT);
  localparam int COL_W  = $clog2(GRID_WIDTH);
  localparam int CNT_W  = $clog2(GRID_HEIGHT + 2);
  localparam int MASK_W = 9;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] ACT_WRITE   = 2'd0;
  localparam logic [1:0] ACT_READ    = 2'd1;
  localparam logic [1:0] ACT_ADVANCE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_BIRTH   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SURVIVE = CFG_IDX_W'(1);

  localparam logic [MASK_W-1:0] BIRTH_RESET   = MASK_W'(8);
  localparam logic [MASK_W-1:0] SURVIVE_RESET = MASK_W'(12);

  typedef struct packed {
    logic [1:0] action;
    logic [5:0] cell_row;
    logic [5:0] cell_col;
    logic       alive_in;
  } item_t;

  typedef struct packed {
    logic       alive_out;
    logic [1:0] done_action;
  } result_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACCESS,
    S_STEP
  } state_e;

  typedef struct packed {
    logic             load;
    logic [ROW_W-1:0] rd_addr;
    logic             win_clear;
    logic             win_shift;
    logic             dn_zero;
    logic             wr_cell;
    logic             wr_step;
    logic [ROW_W-1:0] wr_addr;
    logic             cap_read;
    logic             finish;
  } cmd_t;

  typedef struct packed {
    logic [1:0] action;
  } status_t;

endpackage

@@ hw/rtl/lla_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module lla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/lla_ctrl.sv @@
// Controller: state machine and row counter that sequence cell access and
// generation steps. Depends on lla_pkg.
module lla_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  lla_pkg::item_t   item_i,
  input  lla_pkg::status_t status_i,
  output lla_pkg::cmd_t    cmd_o,
  output logic             busy
);
  import lla_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    busy    = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          unique case (item_i.action) inside
            ACT_WRITE, ACT_READ: begin
              cmd_o.rd_addr = ROW_W'(item_i.cell_row);
              state_d       = S_ACCESS;
            end
            ACT_ADVANCE: begin
              cmd_o.rd_addr   = '0;
              cmd_o.win_clear = 1'b1;
              cnt_d           = CNT_W'(1);
              state_d         = S_STEP;
            end
            default: begin
              cmd_o.finish = 1'b1;
            end
          endcase
        end
      end
      S_ACCESS: begin
        cmd_o.wr_cell  = (status_i.action == ACT_WRITE);
        cmd_o.cap_read = (status_i.action == ACT_READ);
        cmd_o.finish   = 1'b1;
        state_d        = S_IDLE;
      end
      S_STEP: begin
        cmd_o.rd_addr   = ROW_W'(cnt_q);
        cmd_o.win_shift = 1'b1;
        cmd_o.dn_zero   = (cnt_q > CNT_W'(GRID_HEIGHT));
        cmd_o.wr_step   = (cnt_q >= CNT_W'(2));
        cmd_o.wr_addr   = ROW_W'(cnt_q - CNT_W'(2));
        if (cnt_q == CNT_W'(GRID_HEIGHT + 1)) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_STEP |-> cnt_q >= CNT_W'(1) && cnt_q <= CNT_W'(GRID_HEIGHT + 1))
    else $error("step counter out of range");

  a_access_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ACCESS |=> state_q == S_IDLE)
    else $error("cell access lasted more than one cycle");

  a_step_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE && start && item_i.action == ACT_ADVANCE
    |=> state_q == S_STEP && cnt_q == CNT_W'(1))
    else $error("advance did not start at the first row");

  a_step_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wr_step |-> state_q == S_STEP && !cmd_o.wr_cell)
    else $error("row write outside a step");

endmodule

@@ hw/rtl/lla_dp.sv @@
// Datapath: grid memory with per-row valid bits, three-row window, rule lanes
// for one row per cycle, item and result registers. Depends on lla_pkg, lla_ram.
module lla_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lla_pkg::item_t                    item_i,
  input  lla_pkg::cmd_t                     cmd_i,
  input  logic [lla_pkg::MASK_W-1:0]        birth_mask_i,
  input  logic [lla_pkg::MASK_W-1:0]        survive_mask_i,
  output lla_pkg::status_t                  status_o,
  output logic                              done_o,
  output lla_pkg::result_t                  result_o
);
  import lla_pkg::*;

  item_t                 item_q;
  logic                  inside_q;
  logic [ROW_W-1:0]      rd_addr_q;
  logic [GRID_HEIGHT-1:0] valid_q;
  logic [GRID_WIDTH-1:0] ram_rdata;
  logic [GRID_WIDTH-1:0] row_rd;
  logic [GRID_WIDTH-1:0] mid_q, dn_q;
  logic [GRID_WIDTH-1:0] win_dn;
  logic [GRID_WIDTH-1:0] next_row;
  logic [GRID_WIDTH-1:0] cell_row_word;
  logic                  wr_en;
  logic [ROW_W-1:0]      wr_addr;
  logic [GRID_WIDTH-1:0] wr_data;
  logic                  done_q;
  result_t               res_q;

  lla_ram #(
    .WIDTH(GRID_WIDTH),
    .DEPTH(GRID_HEIGHT)
  ) u_grid (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .raddr_i(cmd_i.rd_addr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    rd_addr_q <= cmd_i.rd_addr;
    if (cmd_i.load) begin
      item_q   <= item_i;
      inside_q <= (int'(item_i.cell_row) < GRID_HEIGHT) &&
                  (int'(item_i.cell_col) < GRID_WIDTH);
    end
    if (cmd_i.win_clear) begin
      mid_q <= '0;
      dn_q  <= '0;
    end else if (cmd_i.win_shift) begin
      mid_q <= dn_q;
      dn_q  <= win_dn;
    end
  end

  assign row_rd = valid_q[rd_addr_q] ? ram_rdata : '0;
  assign win_dn = cmd_i.dn_zero ? '0 : row_rd;

  // one rule lane per column
  always_comb begin
    logic [GRID_WIDTH+1:0] up_p, ct_p, dn_p;
    logic [3:0]            cnt;
    logic [MASK_W-1:0]     rule;
    up_p = {1'b0, mid_q, 1'b0};
    ct_p = {1'b0, dn_q, 1'b0};
    dn_p = {1'b0, win_dn, 1'b0};
    next_row = '0;
    for (int c = 0; c < GRID_WIDTH; c++) begin
      cnt = 4'(up_p[c]) + 4'(up_p[c+1]) + 4'(up_p[c+2])
          + 4'(ct_p[c]) + 4'(ct_p[c+2])
          + 4'(dn_p[c]) + 4'(dn_p[c+1]) + 4'(dn_p[c+2]);
      rule = ct_p[c+1] ? survive_mask_i : birth_mask_i;
      next_row[c] = rule[cnt];
    end
  end

  always_comb begin
    cell_row_word = row_rd;
    cell_row_word[COL_W'(item_q.cell_col)] = item_q.alive_in;
  end

  assign wr_en   = cmd_i.wr_step | (cmd_i.wr_cell & inside_q);
  assign wr_addr = cmd_i.wr_step ? cmd_i.wr_addr : ROW_W'(item_q.cell_row);
  assign wr_data = cmd_i.wr_step ? next_row : cell_row_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      done_q  <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
      done_q <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_q.done_action <= cmd_i.load ? item_i.action : item_q.action;
      res_q.alive_out   <= cmd_i.cap_read && inside_q &&
                           row_rd[COL_W'(item_q.cell_col)];
    end
  end

  assign status_o.action = item_q.action;
  assign done_o          = done_q;
  assign result_o        = res_q;

endmodule

@@ hw/rtl/life_like_automaton_grid_step.sv @@
// Top level of the life-like automaton grid block: rule registers, controller
// and datapath. Depends on lla_pkg, lla_ctrl, lla_dp.
//
//   channel  direction  handshake               payload
//   item     in         start, busy             item_i   (item_t)
//   result   out        done_o (strobe)         result_o (result_t)
//   config   in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Write and read items go through S_ACCESS: accepted, row read, strobe next cycle.
// In an advance the grid memory port walks one row per cycle through a
// three-row window, writing rows in place.
// Unused action codes give their result in the cycle after acceptance.
// Reset clears the per-row valid bits at once; no clearing pass is needed.
// The receiver cannot stall: each result shows for exactly one cycle.
module life_like_automaton_grid_step (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  lla_pkg::item_t                    item_i,
  output logic                              done_o,
  output lla_pkg::result_t                  result_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lla_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [lla_pkg::MASK_W-1:0]        cfg_data_i
);
  import lla_pkg::*;

  logic [MASK_W-1:0] birth_q, survive_q;
  cmd_t              cmd;
  status_t           status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      birth_q   <= BIRTH_RESET;
      survive_q <= SURVIVE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_BIRTH:   birth_q   <= cfg_data_i;
        REG_SURVIVE: survive_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lla_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .item_i  (item_i),
    .status_i(status),
    .cmd_o   (cmd),
    .busy    (busy)
  );

  lla_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_i        (item_i),
    .cmd_i         (cmd),
    .birth_mask_i  (birth_q),
    .survive_mask_i(survive_q),
    .status_o      (status),
    .done_o        (done_o),
    .result_o      (result_o)
  );

endmodule
